@@ rtl/rmv_pkg.sv @@
// Shared widths, constants and helper functions of the running mean/variance block.
package rmv_pkg;

  localparam int ENTRIES          = 4096;
  localparam int ADDR_W           = $clog2(ENTRIES);
  localparam int IDX_W            = 12;
  localparam int VAL_W            = 32;
  localparam int SUM_W            = 64;
  localparam int OUT_W            = 31;
  localparam int ITEM_W           = 13;
  localparam int PASS_COUNT_WIDTH = 16;
  localparam int DEN_W            = PASS_COUNT_WIDTH + 1;
  localparam int ROOT_W           = SUM_W / 2;

  localparam logic [OUT_W-1:0]  OUT_MAX  = '1;
  localparam logic [ITEM_W-1:0] ITEM_MAX = '1;
  localparam logic [PASS_COUNT_WIDTH-1:0] PASS_MAX = '1;

  // Saturating unsigned add of two sums.
  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

  // Magnitude of a 33-bit signed difference; always fits in 32 bits.
  function automatic logic [VAL_W-1:0] mag33(input logic signed [VAL_W:0] d);
    logic [VAL_W:0] m;
    m = d[VAL_W] ? (~d + 1'b1) : d;
    return m[VAL_W-1:0];
  endfunction

endpackage

@@ rtl/rmv_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module rmv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/rmv_div.sv @@
// Restoring divider: one quotient bit per cycle, 64-bit dividend.
module rmv_div
  import rmv_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [SUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [SUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_r;
  logic [SUM_W-1:0] quo_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DEN_W:0]   shifted;
  logic             fits;

  assign shifted = {rem_r, quo_r[SUM_W-1]};
  assign fits    = shifted >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !start && busy_r && (cnt_r == CNT_W'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(SUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      rem_r <= '0;
      quo_r <= num;
    end else if (busy_r) begin
      rem_r <= fits ? DEN_W'(shifted - {1'b0, den_r}) : shifted[DEN_W-1:0];
      quo_r <= {quo_r[SUM_W-2:0], fits};
    end
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule

@@ rtl/rmv_sqrt.sv @@
// Digit-by-digit integer square root: one root bit per cycle.
module rmv_sqrt
  import rmv_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SUM_W-1:0]  x,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  localparam int CNT_W = $clog2(ROOT_W + 1);
  localparam int REM_W = ROOT_W + 3;

  logic [SUM_W-1:0]  x_r;
  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;
  logic              fits;

  assign rem_sh = {rem_r[REM_W-3:0], x_r[SUM_W-1:SUM_W-2]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !start && busy_r && (cnt_r == CNT_W'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(ROOT_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= x;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      x_r    <= {x_r[SUM_W-3:0], 2'b00};
      rem_r  <= fits ? (rem_sh - trial) : rem_sh;
      root_r <= {root_r[ROOT_W-2:0], fits};
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

@@ rtl/running_mean_variance_rmse_core.sv @@
// Top level: Welford running mean/variance per entry with per-pass RMSE.
//
// Usage: each input transaction (in_valid high, in_stall low) carries an entry
// index, the true value and a new prediction in signed Q16.16, plus a flag for
// the last item of a pass. Exactly one output transaction follows for each.
// cfg_we writes burnin_mode (reset 1: burn-in, errors only); write it only
// while the block is idle.
// After reset all 4096 entries of the mean and variance memories are swept to
// zero, one entry a cycle, with in_stall held high.
// One item is worked on at a time, with a shared serial divider and a
// shared square-root unit: a sampling item adds a mean division; the
// deviation costs one divide and one root (skipped when no sampling pass is
// finished); the last item of a pass adds two more divide/root pairs.
// The result sits in an output register: when the receiver stalls it holds,
// and the next item may be taken and worked on meanwhile; it waits at the
// end for the register to free up.
module running_mean_variance_rmse_core
  import rmv_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic                    cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [IDX_W-1:0]        in_entry_index,
  input  logic signed [VAL_W-1:0] in_true_value,
  input  logic signed [VAL_W-1:0] in_new_prediction,
  input  logic                    in_last_in_pass,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [IDX_W-1:0]        out_entry_out,
  output logic signed [VAL_W-1:0] out_averaged_prediction,
  output logic [OUT_W-1:0]        out_std_dev,
  output logic [OUT_W-1:0]        out_pass_rmse,
  output logic [OUT_W-1:0]        out_pass_rmse_avg,
  output logic                    out_rmse_valid
);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_RD, S_LD, S_ERR, S_ERRADD, S_MDIV, S_MDIVW,
    S_VMUL, S_VADD, S_AADD, S_STDCHK, S_QDIV, S_QDIVW, S_QSQW, S_DONE
  } state_t;

  typedef enum logic [1:0] {PH_STD, PH_RMSE, PH_RAVG} phase_t;

  state_t state_r;
  phase_t phase_r;

  // Transaction being worked on
  logic [IDX_W-1:0]        idx_r;
  logic signed [VAL_W-1:0] truth_r;
  logic signed [VAL_W-1:0] pred_r;
  logic                    last_r;

  // Working values
  logic signed [VAL_W-1:0] mean_r;
  logic [SUM_W-1:0]        var_r;
  logic signed [VAL_W:0]   delta_r;
  logic                    term_zero_r;
  logic [SUM_W-1:0]        prod_r;
  logic [OUT_W-1:0]        std_r;
  logic [OUT_W-1:0]        rmse_r;
  logic [OUT_W-1:0]        ravg_r;

  // Pass-wide state
  logic [SUM_W-1:0]            err_sum_r;
  logic [SUM_W-1:0]            err_avg_r;
  logic [ITEM_W-1:0]           items_r;
  logic [PASS_COUNT_WIDTH-1:0] passes_r;
  logic                        burnin_r;
  logic [ADDR_W-1:0]           clr_cnt_r;

  // Output register
  logic                    out_valid_r;
  logic [IDX_W-1:0]        out_idx_r;
  logic signed [VAL_W-1:0] out_mean_r;
  logic [OUT_W-1:0]        out_std_r;
  logic [OUT_W-1:0]        out_rmse_r;
  logic [OUT_W-1:0]        out_ravg_r;
  logic                    out_last_r;

  // Memories
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ADDR_W-1:0] ram_raddr;
  logic [VAL_W-1:0]  mean_wdata;
  logic [VAL_W-1:0]  mean_rdata;
  logic [SUM_W-1:0]  var_wdata;
  logic [SUM_W-1:0]  var_rdata;

  // Shared units
  logic              div_start;
  logic [SUM_W-1:0]  div_num;
  logic [DEN_W-1:0]  div_den;
  logic              div_done;
  logic [SUM_W-1:0]  div_quot;
  logic              sqrt_start;
  logic              sqrt_done;
  logic [ROOT_W-1:0] sqrt_root;
  logic [OUT_W-1:0]  root_sat;

  logic [VAL_W-1:0]        mul_a;
  logic [VAL_W-1:0]        mul_b;
  logic signed [VAL_W:0]   rest;
  logic signed [VAL_W+1:0] nmean;
  logic [VAL_W+1:0]        q_ext;
  logic                    out_free;
  logic                    in_take;

  assign in_take  = in_valid && (state_r == S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  assign rest  = {pred_r[VAL_W-1], pred_r} - {mean_r[VAL_W-1], mean_r};
  assign q_ext = {2'b00, div_quot[VAL_W-1:0]};
  assign nmean = {{2{mean_r[VAL_W-1]}}, mean_r} +
                 (delta_r[VAL_W] ? (~q_ext + 1'b1) : q_ext);

  assign root_sat = sqrt_root[ROOT_W-1] ? OUT_MAX : sqrt_root[OUT_W-1:0];

  // Shared multiplier operands, chosen by step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_ERR: begin
        mul_a = mag33({truth_r[VAL_W-1], truth_r} - {pred_r[VAL_W-1], pred_r});
        mul_b = mul_a;
      end
      S_VMUL: begin
        mul_a = mag33(delta_r);
        mul_b = mag33(rest);
      end
      S_VADD: begin
        mul_a = mag33({truth_r[VAL_W-1], truth_r} - {mean_r[VAL_W-1], mean_r});
        mul_b = mul_a;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Divider operands
  always_comb begin
    div_start = (state_r == S_MDIV) || (state_r == S_QDIV);
    if (state_r == S_MDIV) begin
      div_num = {{(SUM_W-VAL_W){1'b0}}, mag33(delta_r)};
      div_den = {1'b0, passes_r} + DEN_W'(1);
    end else begin
      case (phase_r)
        PH_STD: begin
          div_num = var_r;
          div_den = DEN_W'(passes_r);
        end
        PH_RMSE: begin
          div_num = err_sum_r;
          div_den = DEN_W'(items_r);
        end
        default: begin
          div_num = err_avg_r;
          div_den = DEN_W'(items_r);
        end
      endcase
    end
  end

  assign sqrt_start = (state_r == S_QDIVW) && div_done;

  // Memory ports: sweep during clear, write back after the update
  assign ram_we     = (state_r == S_CLR) || (state_r == S_AADD);
  assign ram_waddr  = (state_r == S_CLR) ? clr_cnt_r : idx_r[ADDR_W-1:0];
  assign ram_raddr  = idx_r[ADDR_W-1:0];
  assign mean_wdata = (state_r == S_CLR) ? '0 : mean_r;
  assign var_wdata  = (state_r == S_CLR) ? '0 : var_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      phase_r     <= PH_STD;
      clr_cnt_r   <= '0;
      err_sum_r   <= '0;
      err_avg_r   <= '0;
      items_r     <= '0;
      passes_r    <= '0;
      burnin_r    <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      prod_r <= {{(SUM_W-VAL_W){1'b0}}, mul_a} * {{(SUM_W-VAL_W){1'b0}}, mul_b};
      if (cfg_we) begin
        burnin_r <= cfg_wdata;
      end
      // Drop the result once the receiver takes it, unless a new one loads now
      if (out_valid_r && !out_stall && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_CLR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == ADDR_W'(ENTRIES - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_take) begin
            idx_r   <= in_entry_index;
            truth_r <= in_true_value;
            pred_r  <= in_new_prediction;
            last_r  <= in_last_in_pass;
            state_r <= S_RD;
          end
        end
        S_RD: state_r <= S_LD;
        S_LD: begin
          mean_r  <= mean_rdata;
          var_r   <= var_rdata;
          state_r <= S_ERR;
        end
        S_ERR: state_r <= S_ERRADD;
        S_ERRADD: begin
          err_sum_r <= sat_add(err_sum_r, prod_r);
          if (items_r != ITEM_MAX) begin
            items_r <= items_r + 1'b1;
          end
          delta_r <= {pred_r[VAL_W-1], pred_r} - {mean_r[VAL_W-1], mean_r};
          state_r <= burnin_r ? S_STDCHK : S_MDIV;
        end
        S_MDIV: state_r <= S_MDIVW;
        S_MDIVW: begin
          if (div_done) begin
            mean_r  <= nmean[VAL_W-1:0];
            state_r <= S_VMUL;
          end
        end
        S_VMUL: begin
          // A product of opposite-signed nonzero factors counts as zero
          term_zero_r <= (delta_r[VAL_W] != rest[VAL_W]) && (delta_r != '0) && (rest != '0);
          state_r     <= S_VADD;
        end
        S_VADD: begin
          var_r   <= sat_add(var_r, term_zero_r ? '0 : prod_r);
          state_r <= S_AADD;
        end
        S_AADD: begin
          err_avg_r <= sat_add(err_avg_r, prod_r);
          state_r   <= S_STDCHK;
        end
        S_STDCHK: begin
          rmse_r <= '0;
          ravg_r <= '0;
          if (passes_r == '0) begin
            std_r   <= '0;
            phase_r <= PH_RMSE;
            state_r <= last_r ? S_QDIV : S_DONE;
          end else begin
            phase_r <= PH_STD;
            state_r <= S_QDIV;
          end
        end
        S_QDIV: state_r <= S_QDIVW;
        S_QDIVW: begin
          if (div_done) begin
            state_r <= S_QSQW;
          end
        end
        S_QSQW: begin
          if (sqrt_done) begin
            case (phase_r)
              PH_STD: begin
                std_r   <= root_sat;
                phase_r <= PH_RMSE;
                state_r <= last_r ? S_QDIV : S_DONE;
              end
              PH_RMSE: begin
                rmse_r  <= root_sat;
                phase_r <= PH_RAVG;
                state_r <= S_QDIV;
              end
              default: begin
                ravg_r  <= root_sat;
                state_r <= S_DONE;
              end
            endcase
          end
        end
        S_DONE: begin
          // Hold until the output register is free, then close the pass if due
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_idx_r   <= idx_r;
            out_mean_r  <= mean_r;
            out_std_r   <= std_r;
            out_rmse_r  <= last_r ? rmse_r : '0;
            out_ravg_r  <= last_r ? ravg_r : '0;
            out_last_r  <= last_r;
            if (last_r) begin
              err_sum_r <= '0;
              err_avg_r <= '0;
              items_r   <= '0;
              if (!burnin_r && passes_r != PASS_MAX) begin
                passes_r <= passes_r + 1'b1;
              end
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  rmv_ram #(.WIDTH(VAL_W), .DEPTH(ENTRIES)) u_mean_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (mean_wdata),
    .raddr (ram_raddr),
    .rdata (mean_rdata)
  );

  rmv_ram #(.WIDTH(SUM_W), .DEPTH(ENTRIES)) u_var_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (var_wdata),
    .raddr (ram_raddr),
    .rdata (var_rdata)
  );

  rmv_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  rmv_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .x     (div_quot),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  assign in_stall                = (state_r != S_IDLE);
  assign out_valid               = out_valid_r;
  assign out_entry_out           = out_idx_r;
  assign out_averaged_prediction = out_mean_r;
  assign out_std_dev             = out_std_r;
  assign out_pass_rmse           = out_rmse_r;
  assign out_pass_rmse_avg       = out_ravg_r;
  assign out_rmse_valid          = out_last_r;

endmodule

@@ rtl/rmv_checker.sv @@
// Port-level checker for the running mean/variance block, bound to the top level.
module rmv_checker
  import rmv_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic [OUT_W-1:0]        out_pass_rmse,
  input logic [OUT_W-1:0]        out_pass_rmse_avg,
  input logic                    out_rmse_valid
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // One transaction at a time: busy right after an accept
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again before work finished");

  // RMSE fields are zero outside a pass end
  a_rmse_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_rmse_valid |-> out_pass_rmse == '0 && out_pass_rmse_avg == '0)
    else $error("RMSE fields nonzero on a mid-pass result");

  // Reset leaves no result pending
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind running_mean_variance_rmse_core rmv_checker u_rmv_checker (.*);

@@ test/tb.sv @@
// Self-checking testbench for the running mean/variance/RMSE core.
module tb;
  import rmv_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // One result transaction as the block reports it.
  typedef struct packed {
    logic [IDX_W-1:0]        entry;
    logic signed [VAL_W-1:0] mean;
    logic [OUT_W-1:0]        sd;
    logic [OUT_W-1:0]        rmse;
    logic [OUT_W-1:0]        rmse_mean;
    logic                    rvalid;
  } rmv_result_t;

  // Welford tracker: holds its own copy of the block's state, predicts each
  // result as the input is taken, and checks results in order.
  class welford_scoreboard;
    logic signed [VAL_W-1:0] means[ENTRIES];
    logic [SUM_W-1:0]        var_sums[ENTRIES];
    logic [SUM_W-1:0]        err_sum, err_sum_avg;
    logic [ITEM_W-1:0]       item_cnt;
    logic [PASS_COUNT_WIDTH-1:0] pass_cnt;
    logic                    burnin;
    rmv_result_t             pending[$];
    int                      mismatches, checked, rmse_seen;

    function new();
      for (int i = 0; i < ENTRIES; i++) begin
        means[i] = '0;
        var_sums[i] = '0;
      end
      err_sum = '0; err_sum_avg = '0; item_cnt = '0; pass_cnt = '0;
      burnin = 1'b1; mismatches = 0; checked = 0; rmse_seen = 0;
    endfunction

    function logic [SUM_W-1:0] add_sat(logic [SUM_W-1:0] a, logic [SUM_W-1:0] b);
      logic [SUM_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[SUM_W] ? '1 : s[SUM_W-1:0];
    endfunction

    function logic [SUM_W-1:0] square_of(longint d);
      logic [SUM_W-1:0] m;
      m = (d < 0) ? -d : d;
      return m * m;
    endfunction

    // Floor of the square root of floor(num/den), clipped to 31 bits.
    function logic [OUT_W-1:0] root_quot(logic [SUM_W-1:0] num, logic [SUM_W-1:0] den);
      logic [SUM_W-1:0] x, res, bit_v;
      if (den == 0) return '0;
      x = num / den;
      res = 0;
      bit_v = 64'h1 << 62;
      while (bit_v > x) bit_v >>= 2;
      while (bit_v != 0) begin
        if (x >= res + bit_v) begin
          x -= res + bit_v;
          res = (res >> 1) + bit_v;
        end else begin
          res >>= 1;
        end
        bit_v >>= 2;
      end
      return (res > 64'h7FFF_FFFF) ? OUT_MAX : res[OUT_W-1:0];
    endfunction

    function void note_input(logic [IDX_W-1:0] idx, logic signed [VAL_W-1:0] truth,
                             logic signed [VAL_W-1:0] pred, logic last);
      rmv_result_t r;
      longint mean_v, delta, nmean, rest, t, p;
      logic [SUM_W-1:0] ad, ar, term;
      t = truth;
      p = pred;
      mean_v = means[idx];
      err_sum = add_sat(err_sum, square_of(t - p));
      if (!burnin) begin
        delta = p - mean_v;
        nmean = mean_v + delta / (longint'(pass_cnt) + 1);
        rest = p - nmean;
        ad = (delta < 0) ? -delta : delta;
        ar = (rest < 0) ? -rest : rest;
        term = (((delta < 0) != (rest < 0)) && ad != 0 && ar != 0) ? '0 : ad * ar;
        var_sums[idx] = add_sat(var_sums[idx], term);
        means[idx] = nmean[VAL_W-1:0];
        mean_v = nmean;
        err_sum_avg = add_sat(err_sum_avg, square_of(t - nmean));
      end
      if (item_cnt != ITEM_MAX) item_cnt++;
      r.entry = idx;
      r.mean = mean_v[VAL_W-1:0];
      r.sd = root_quot(var_sums[idx], pass_cnt);
      r.rmse = last ? root_quot(err_sum, item_cnt) : '0;
      r.rmse_mean = last ? root_quot(err_sum_avg, item_cnt) : '0;
      r.rvalid = last;
      if (last) begin
        err_sum = '0; err_sum_avg = '0; item_cnt = '0;
        if (!burnin && pass_cnt != PASS_MAX) pass_cnt++;
      end
      pending.insert(pending.size(), r);
    endfunction

    function void check_result(rmv_result_t got);
      rmv_result_t exp_r;
      checked++;
      if (got.rvalid) rmse_seen++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result for entry %0d", got.entry);
        return;
      end
      exp_r = pending.pop_front();
      if (got !== exp_r) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch #%0d: exp e=%0d m=%0d sd=%0d r=%0d ra=%0d v=%0b",
                   checked, exp_r.entry, exp_r.mean, exp_r.sd, exp_r.rmse,
                   exp_r.rmse_mean, exp_r.rvalid);
          $display("              got e=%0d m=%0d sd=%0d r=%0d ra=%0d v=%0b",
                   got.entry, got.mean, got.sd, got.rmse, got.rmse_mean, got.rvalid);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0, cfg_wdata = 1'b0;
  logic in_valid = 1'b0, in_last_in_pass = 1'b0;
  logic in_stall, out_valid, out_stall = 1'b0, out_rmse_valid;
  logic [IDX_W-1:0] in_entry_index = '0, out_entry_out;
  logic signed [VAL_W-1:0] in_true_value = '0, in_new_prediction = '0;
  logic signed [VAL_W-1:0] out_averaged_prediction;
  logic [OUT_W-1:0] out_std_dev, out_pass_rmse, out_pass_rmse_avg;
  bit stall_rx = 1'b0;
  int sent = 0;
  welford_scoreboard sb = new();

  always #2 clk = ~clk;

  running_mean_variance_rmse_core u_dut (.*);

  // Gap length: none at all half the time, otherwise mostly short, occasionally long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 400);
  endfunction

  // Sample results and drive the receiver's stall at each rising edge.
  initial begin
    int hold;
    rmv_result_t got;
    hold = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got.entry = out_entry_out;
        got.mean = out_averaged_prediction;
        got.sd = out_std_dev;
        got.rmse = out_pass_rmse;
        got.rmse_mean = out_pass_rmse_avg;
        got.rvalid = out_rmse_valid;
        sb.check_result(got);
      end
      if (hold > 0) hold--;
      else if (stall_rx) hold = gap_len();
      out_stall <= (hold > 0);
    end
  end

  // Push one input transaction and hold it until accepted; valid stays high
  // into the next transaction when there is no gap.
  task automatic send_item(logic [IDX_W-1:0] idx, logic signed [VAL_W-1:0] truth,
                           logic signed [VAL_W-1:0] pred, logic last);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_entry_index <= idx;
    in_true_value <= truth;
    in_new_prediction <= pred;
    in_last_in_pass <= last;
    do @(posedge clk); while (in_stall);
    sb.note_input(idx, truth, pred, last);
    sent++;
  endtask

  // Wait for the block to drain, then write burn-in mode.
  task automatic set_mode(logic burnin);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= burnin;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.burnin = burnin;
  endtask

  // A pass over a small set of entries with predictions mostly near the truth.
  task automatic run_pass(int n, int base);
    logic signed [VAL_W-1:0] truth, pred;
    logic [IDX_W-1:0] idx;
    for (int i = 0; i < n; i++) begin
      idx = IDX_W'((base + i) % ENTRIES);
      truth = $urandom_range(0, 3) == 0 ? $urandom : $signed($urandom_range(0, 20'hFFFFF)) - 20'sh80000;
      pred = $urandom_range(0, 5) == 0 ? $urandom : truth + $signed($urandom_range(0, 16'hFFFF)) - 32'sh8000;
      send_item(idx, truth, pred, i == n - 1);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: burn-in with extreme values, sampling passes, one more burn-in item, then sampling again.
    send_item('0, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0);
    send_item('1, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
    send_item(12'd5, 32'sh0001_0000, 32'sh0001_0000, 1'b1);
    send_item(12'd5, 32'sh0, 32'sh0, 1'b1);
    set_mode(1'b0);
    send_item('0, 32'sh0, 32'sh7FFF_FFFF, 1'b0);
    send_item('1, 32'sh0, 32'sh8000_0000, 1'b0);
    send_item(12'd5, 32'sh0002_0000, 32'sh0003_0000, 1'b1);
    send_item('0, 32'sh0, 32'sh8000_0000, 1'b0);
    send_item('1, 32'sh0, 32'sh7FFF_FFFF, 1'b0);
    send_item(12'd5, 32'sh0002_0000, 32'shFFFF_0000, 1'b1);
    send_item(12'd5, 32'sh1234_5678, 32'sh0000_0001, 1'b1);
    set_mode(1'b1);
    send_item(12'd5, 32'sh0, 32'sh0000_FFFF, 1'b1);
    set_mode(1'b0);

    // Random: mostly sampling passes over a small entry set, occasional burn-in
    // stretches, and receiver stalls switched on and off.
    stall_rx = 1'b1;
    while (sent < 1500) begin
      run_pass($urandom_range(1, 12), $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 15));
      if ($urandom_range(0, 15) == 0) stall_rx = ~stall_rx;
      if ($urandom_range(0, 40) == 0) begin
        set_mode(1'b1);
        run_pass($urandom_range(1, 8), $urandom_range(0, 15));
        set_mode(1'b0);
      end
    end
    in_valid <= 1'b0;
    stall_rx = 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    $display("tb: %0d transactions sent, %0d results checked",
             sent, sb.checked);
    $display("tb: %0d pass ends seen, %0d sampling passes finished",
             sb.rmse_seen, sb.pass_cnt);
    if (sb.mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("tb: FAIL");
    end
    $finish;
  end

  // Timeout: room for 1500 slow items plus long gaps and stalls,
  // several times over.
  initial begin
    #40ms;
    $display("tb: timeout");
    $display("tb: FAIL");
    $finish;
  end
endmodule

@@ sim.f @@
rtl/rmv_pkg.sv
rtl/rmv_ram.sv
rtl/rmv_div.sv
rtl/rmv_sqrt.sv
rtl/running_mean_variance_rmse_core.sv
rtl/rmv_checker.sv
test/tb.sv
